// ----- sv/atda_pkg.sv -----
package atda_pkg;

    localparam int MAX_BLOCKS_DEF   = 32;
    localparam int HEADER_BYTES_DEF = 12;
    localparam int ALIGN_BYTES_DEF  = 4;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_STATS = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_BADREQ   = 2'd3;

    localparam logic [15:0] ARENA_RESET = 16'd4096;

    // command broadcast into the cell chain
    typedef struct packed {
        logic        probe;
        logic [16:0] lo;
        logic [17:0] hi;
        logic        release_chk;
        logic [16:0] match_off;
        logic        write;
        logic        clear;
        logic [16:0] wr_start;
        logic [15:0] wr_payload;
    } atda_cmd_t;

    // summary handed along the chain from cell to cell
    typedef struct packed {
        logic        collide;
        logic        found;
        logic        have_free;
        logic [17:0] span;
    } atda_link_t;

endpackage

// ----- sv/atda_cell.sv -----
module atda_cell
    import atda_pkg::*;
#(
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  atda_cmd_t  cmd,
    input  logic       sel,
    input  logic       clr_sel,
    input  atda_link_t link_in,
    output atda_link_t link_out,
    output logic       live,
    output logic       hit
);

    logic        live_reg;
    logic [16:0] start_reg;
    logic [15:0] payload_reg;
    logic [17:0] end_val;
    logic        coll;

    assign end_val = {1'b0, start_reg} + 18'(HEADER_BYTES) + {2'b0, payload_reg};
    assign coll = live_reg && cmd.probe && ({1'b0, cmd.lo} < end_val) &&
                  (cmd.hi > {1'b0, start_reg});
    assign hit = live_reg && cmd.release_chk &&
                 (start_reg + 17'(HEADER_BYTES) == cmd.match_off);
    assign live = live_reg;

    always_comb begin
        link_out = link_in;
        link_out.collide = link_in.collide | coll;
        link_out.have_free = link_in.have_free | ~live_reg;
        if (hit && !link_in.found) begin
            link_out.found = 1'b1;
            link_out.span = 18'(HEADER_BYTES) + {2'b0, payload_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            live_reg <= 1'b0;
        end else if (cmd.write && sel) begin
            live_reg <= 1'b1;
        end else if (cmd.clear && clr_sel) begin
            live_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write && sel) begin
            start_reg <= cmd.wr_start;
            payload_reg <= cmd.wr_payload;
        end
    end

endmodule

// ----- sv/atda_chain.sv -----
module atda_chain
    import atda_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  atda_cmd_t  cmd,
    output atda_link_t summary
);

    atda_link_t            link [MAX_BLOCKS+1];
    logic [MAX_BLOCKS-1:0] live_v;
    logic [MAX_BLOCKS-1:0] hit_v;
    logic [MAX_BLOCKS-1:0] sel_v;
    logic [MAX_BLOCKS-1:0] clr_v;

    assign link[0] = '0;

    // lowest free entry and first matching entry
    assign sel_v = ~live_v & (live_v + MAX_BLOCKS'(1));
    assign clr_v = hit_v & (~hit_v + MAX_BLOCKS'(1));

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
            atda_cell #(.HEADER_BYTES(HEADER_BYTES)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd),
                .sel     (sel_v[g]),
                .clr_sel (clr_v[g]),
                .link_in (link[g]),
                .link_out(link[g+1]),
                .live    (live_v[g]),
                .hit     (hit_v[g])
            );
        end
    endgenerate

    assign summary = link[MAX_BLOCKS];

endmodule

// ----- sv/arena_top_down_allocator_top.sv -----
// channel  dir  tdata fields (low bit up)
// s_axis   in   operation[1:0] request_size[17:2] release_offset[33:18]
// m_axis   out  status[1:0] payload_offset[17:2] used_bytes[33:18] free_bytes[49:34]
// apb      in   arena_bytes at address 0
// stats, unused op and bad allocate: the first probe state goes straight to the result;
// free: probe, then evaluate; allocate: tries aligned starts from the top down, up to
// (arena_bytes - HEADER_BYTES - size)/ALIGN_BYTES + 1 starts; table full after one try
// each try is a probe step over the chain of block cells and then an evaluate step
// one item at a time; s_tready low while busy or while a result waits
// aresetn clears all entries at once, no clearing pass
module arena_top_down_allocator_top
    import atda_pkg::*;
#(
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // operation, request_size, release_offset
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,  // status, payload_offset, used_bytes, free_bytes
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_EVAL  = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] arena_reg;
    logic [15:0] used_reg, used_next;
    logic [1:0]  op_reg;
    logic [15:0] size_reg;
    logic [15:0] off_reg;
    logic [16:0] pos_reg, pos_next;
    logic [16:0] need_reg;
    logic [1:0]  st_reg, st_next;
    logic [15:0] po_reg, po_next;
    logic        first_reg, first_next;
    atda_cmd_t   cmd;
    atda_link_t  sum;
    atda_link_t  sum_reg;
    logic [16:0] need_w;
    logic [16:0] top_w;
    logic [17:0] used_add;
    logic [15:0] free_w;

    assign pready = 1'b1;
    assign prdata = {16'b0, arena_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arena_reg <= ARENA_RESET;
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            arena_reg <= pwdata[15:0];
        end
    end

    atda_chain #(.MAX_BLOCKS(MAX_BLOCKS), .HEADER_BYTES(HEADER_BYTES)) u_chain (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .summary(sum)
    );

    assign need_w = 17'(HEADER_BYTES) + {1'b0, size_reg};
    assign top_w = (17'({1'b0, arena_reg}) - need_w) / 17'(ALIGN_BYTES) * 17'(ALIGN_BYTES);
    assign used_add = {2'b0, used_reg} + {1'b0, need_reg};

    always_comb begin
        cmd = '0;
        cmd.probe = (state_reg == S_PROBE);
        cmd.lo = pos_reg;
        cmd.hi = {1'b0, pos_reg} + {1'b0, need_reg};
        cmd.release_chk = (state_reg == S_PROBE);
        cmd.match_off = {1'b0, off_reg};
        cmd.wr_start = pos_reg;
        cmd.wr_payload = size_reg;
        if (state_reg == S_EVAL) begin
            cmd.write = (op_reg == OP_ALLOC) && !sum_reg.collide && st_reg == ST_OK;
            cmd.clear = (op_reg == OP_FREE) && sum_reg.found;
            cmd.release_chk = cmd.clear;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum;
    end

    always_comb begin
        state_next = state_reg;
        used_next = used_reg;
        pos_next = pos_reg;
        st_next = st_reg;
        po_next = po_reg;
        first_next = first_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_PROBE;
                    st_next = ST_OK;
                    po_next = '0;
                    first_next = 1'b1;
                end
            end
            S_PROBE: begin
                state_next = S_EVAL;
                if (first_reg) begin
                    first_next = 1'b0;
                    case (op_reg)
                        OP_ALLOC: begin
                            if (size_reg == 16'd0 || need_w > {1'b0, arena_reg}) begin
                                st_next = ST_BADREQ;
                                state_next = S_OUT;
                            end else begin
                                pos_next = top_w;
                                state_next = S_PROBE;
                            end
                        end
                        OP_FREE:  state_next = S_EVAL;
                        OP_STATS: state_next = S_OUT;
                        default: begin
                            st_next = ST_BADREQ;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_EVAL: begin
                state_next = S_OUT;
                if (op_reg == OP_ALLOC) begin
                    if (!sum_reg.have_free) begin
                        st_next = ST_NOSPACE;
                    end else if (!sum_reg.collide) begin
                        po_next = 16'(pos_reg + 17'(HEADER_BYTES));
                        used_next = used_add[17:16] != 2'b0 ? 16'hFFFF : used_add[15:0];
                    end else if (pos_reg < 17'(ALIGN_BYTES)) begin
                        st_next = ST_NOSPACE;
                    end else begin
                        pos_next = pos_reg - 17'(ALIGN_BYTES);
                        state_next = S_PROBE;
                    end
                end else begin
                    if (sum_reg.found) begin
                        used_next = {2'b0, used_reg} > sum_reg.span ?
                                    16'({2'b0, used_reg} - sum_reg.span) : 16'd0;
                    end else begin
                        st_next = ST_NOTFOUND;
                    end
                end
            end
            S_OUT: begin
                if (m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg <= '0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg <= used_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        st_reg <= st_next;
        po_reg <= po_next;
        if (state_reg == S_IDLE && s_tvalid) begin
            op_reg <= s_tdata[1:0];
            size_reg <= s_tdata[17:2];
            off_reg <= s_tdata[33:18];
        end
        if (state_reg == S_PROBE && first_reg) begin
            need_reg <= need_w;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign free_w = arena_reg > used_reg ? arena_reg - used_reg : 16'd0;
    assign m_tdata = {6'b0, free_w, used_reg, (st_reg == ST_OK ? po_reg : 16'd0), st_reg};

endmodule
